FILE: rtl/core/nbpf_pkg.sv
// Shared types and constants for the pairwise force sum core.
// Used by the channel interfaces, the controller, the datapath and the top level.
package nbpf_pkg;

    localparam int MaxBodies = 2048;

    localparam int PosW     = 24;
    localparam int MassW    = 16;
    localparam int IdxW     = 11;
    localparam int ForceW   = 40;
    localparam int GravW    = 20;
    localparam int LimW     = 24;
    localparam int CountW   = 12;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 24;

    localparam int DiffW = PosW + 1;
    localparam int SqW   = 2 * PosW + 1;
    localparam int D2W   = SqW + 1;
    localparam int GmW   = GravW + MassW;
    localparam int NumW  = GmW + MassW;
    localparam int QW    = 24;
    localparam int BitW  = 49;
    localparam int RootW = 50;
    localparam int DistW = 26;
    localparam int ProdW = DistW + QW - 1;
    localparam int DrW   = NumW + 16;
    localparam int DdenW = D2W + QW - 1;

    localparam int RootSteps = 25;
    localparam int DivSteps  = 24;
    localparam int CntW      = 5;

    localparam logic [CfgIdxW-1:0] CFG_BODY_COUNT  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_GRAVITY     = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_FORCE_LIMIT = 2'd2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [CountW-1:0] BodyCountReset = 12'd2048;
    localparam logic [GravW-1:0]  GravityReset   = 20'd43740;
    localparam logic [LimW-1:0]   LimitReset     = 24'd196608;

    typedef enum logic [3:0] {
        S_IDLE, S_HOME, S_NEXT, S_DIFF, S_SQ, S_SUM, S_CHK,
        S_ITER, S_MAG, S_MUL, S_CDIV, S_ACC, S_DONE
    } t_state;

    typedef struct packed {
        logic rd_input;
        logic query_start;
        logic load_we;
        logic home_load;
        logic j_inc;
        logic diff_load;
        logic sq_load;
        logic sum_load;
        logic iter_init;
        logic root_step;
        logic div_step;
        logic mag_load;
        logic mul_load;
        logic cdiv_step;
        logic acc_add;
        logic seen_set;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic idx_ok;
        logic j_end;
        logic j_home;
        logic d2_zero;
    } t_stat;

endpackage

FILE: rtl/core/nbpf_if.sv
// Valid/ready channel interfaces for body transactions in and force results out.
// Depends on nbpf_pkg for the field widths.
interface nbpf_in_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [nbpf_pkg::IdxW-1:0]       body_index;
    logic signed [nbpf_pkg::PosW-1:0] pos_x;
    logic signed [nbpf_pkg::PosW-1:0] pos_y;
    logic signed [nbpf_pkg::PosW-1:0] pos_z;
    logic [nbpf_pkg::MassW-1:0]      body_mass;

    modport source (output valid, kind, body_index, pos_x, pos_y, pos_z, body_mass,
                    input ready);
    modport sink (input valid, kind, body_index, pos_x, pos_y, pos_z, body_mass,
                  output ready);
endinterface

interface nbpf_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [nbpf_pkg::ForceW-1:0] force_x;
    logic signed [nbpf_pkg::ForceW-1:0] force_y;
    logic signed [nbpf_pkg::ForceW-1:0] force_z;
    logic                               coincident_seen;

    modport source (output valid, force_x, force_y, force_z, coincident_seen, input ready);
    modport sink (input valid, force_x, force_y, force_z, coincident_seen, output ready);
endinterface

FILE: rtl/core/nbpf_ctrl.sv
// Sequencer for loads and queries: walks the body table one pair at a time.
// Depends on nbpf_pkg for the state, command and status types.
module nbpf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_kind,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  nbpf_pkg::t_stat i_stat,
    output nbpf_pkg::t_cmd  o_cmd
);

    nbpf_pkg::t_state r_state, n_state;
    logic [nbpf_pkg::CntW-1:0] r_cnt, n_cnt;
    logic r_out_valid, n_out_valid;
    logic accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nbpf_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == nbpf_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            nbpf_pkg::S_IDLE: begin
                o_cmd.rd_input = 1'b1;
                if (accept && i_in_kind == nbpf_pkg::KIND_LOAD) begin
                    o_cmd.load_we = 1'b1;
                end
                if (accept && i_in_kind == nbpf_pkg::KIND_QUERY) begin
                    o_cmd.query_start = 1'b1;
                    n_state = i_stat.idx_ok ? nbpf_pkg::S_HOME : nbpf_pkg::S_DONE;
                end
            end
            nbpf_pkg::S_HOME: begin
                o_cmd.home_load = 1'b1;
                n_state = nbpf_pkg::S_NEXT;
            end
            nbpf_pkg::S_NEXT: begin
                if (i_stat.j_end) begin
                    n_state = nbpf_pkg::S_DONE;
                end else if (i_stat.j_home) begin
                    o_cmd.j_inc = 1'b1;
                end else begin
                    n_state = nbpf_pkg::S_DIFF;
                end
            end
            nbpf_pkg::S_DIFF: begin
                o_cmd.diff_load = 1'b1;
                n_state = nbpf_pkg::S_SQ;
            end
            nbpf_pkg::S_SQ: begin
                o_cmd.sq_load = 1'b1;
                n_state = nbpf_pkg::S_SUM;
            end
            nbpf_pkg::S_SUM: begin
                o_cmd.sum_load = 1'b1;
                n_state = nbpf_pkg::S_CHK;
            end
            nbpf_pkg::S_CHK: begin
                n_cnt = '0;
                if (i_stat.d2_zero) begin
                    // Coincident pair: flag it and move on to the next body.
                    o_cmd.seen_set = 1'b1;
                    o_cmd.j_inc    = 1'b1;
                    n_state = nbpf_pkg::S_NEXT;
                end else begin
                    o_cmd.iter_init = 1'b1;
                    n_state = nbpf_pkg::S_ITER;
                end
            end
            nbpf_pkg::S_ITER: begin
                o_cmd.root_step = 1'b1;
                o_cmd.div_step  = (r_cnt < nbpf_pkg::CntW'(nbpf_pkg::DivSteps));
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == nbpf_pkg::CntW'(nbpf_pkg::RootSteps - 1)) begin
                    n_state = nbpf_pkg::S_MAG;
                end
            end
            nbpf_pkg::S_MAG: begin
                o_cmd.mag_load = 1'b1;
                n_state = nbpf_pkg::S_MUL;
            end
            nbpf_pkg::S_MUL: begin
                o_cmd.mul_load = 1'b1;
                n_cnt = '0;
                n_state = nbpf_pkg::S_CDIV;
            end
            nbpf_pkg::S_CDIV: begin
                o_cmd.cdiv_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == nbpf_pkg::CntW'(nbpf_pkg::DivSteps - 1)) begin
                    n_state = nbpf_pkg::S_ACC;
                end
            end
            nbpf_pkg::S_ACC: begin
                o_cmd.acc_add = 1'b1;
                o_cmd.j_inc   = 1'b1;
                n_state = nbpf_pkg::S_NEXT;
            end
            nbpf_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = nbpf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nbpf_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/nbpf_dpath.sv
// Datapath: body table memories, configuration registers, pair arithmetic
// (squares, restoring divider, integer square root, component dividers), accumulators.
// Depends on nbpf_pkg for widths and the command and status types.
module nbpf_dpath #(
    parameter int MAX_BODIES = nbpf_pkg::MaxBodies
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  nbpf_pkg::t_cmd                      i_cmd,
    output nbpf_pkg::t_stat                     o_stat,
    input  logic [nbpf_pkg::IdxW-1:0]           i_body_index,
    input  logic signed [nbpf_pkg::PosW-1:0]    i_pos_x,
    input  logic signed [nbpf_pkg::PosW-1:0]    i_pos_y,
    input  logic signed [nbpf_pkg::PosW-1:0]    i_pos_z,
    input  logic [nbpf_pkg::MassW-1:0]          i_body_mass,
    input  logic                                i_cfg_we,
    input  logic [nbpf_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  logic [nbpf_pkg::CfgDataW-1:0]       i_cfg_data,
    output logic signed [nbpf_pkg::ForceW-1:0]  o_force_x,
    output logic signed [nbpf_pkg::ForceW-1:0]  o_force_y,
    output logic signed [nbpf_pkg::ForceW-1:0]  o_force_z,
    output logic                                o_coincident_seen
);

    localparam int AW = $clog2(MAX_BODIES);
    localparam int CW = AW + 1;

    logic [nbpf_pkg::PosW-1:0]  mem_x [MAX_BODIES];
    logic [nbpf_pkg::PosW-1:0]  mem_y [MAX_BODIES];
    logic [nbpf_pkg::PosW-1:0]  mem_z [MAX_BODIES];
    logic [nbpf_pkg::MassW-1:0] mem_m [MAX_BODIES];

    logic [nbpf_pkg::PosW-1:0]  r_rd_p [3];
    logic [nbpf_pkg::MassW-1:0] r_rd_m;

    logic [nbpf_pkg::CountW-1:0] r_cfg_count;
    logic [nbpf_pkg::GravW-1:0]  r_cfg_g;
    logic [nbpf_pkg::LimW-1:0]   r_cfg_lim;

    logic [AW-1:0] r_home;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_j;

    logic [nbpf_pkg::PosW-1:0]       r_home_p [3];
    logic [nbpf_pkg::GmW-1:0]        r_gm;
    logic [nbpf_pkg::MassW-1:0]      r_mj;
    logic signed [nbpf_pkg::DiffW-1:0] r_d [3];
    logic [nbpf_pkg::SqW-1:0]        r_sq [3];
    logic [nbpf_pkg::NumW-1:0]       r_num;
    logic [nbpf_pkg::D2W-1:0]        r_d2;
    logic                            r_sat;

    logic [nbpf_pkg::DrW-1:0]   r_dr;
    logic [nbpf_pkg::DdenW-1:0] r_dden;
    logic [nbpf_pkg::QW-1:0]    r_q;

    logic [nbpf_pkg::RootW-1:0] r_rx;
    logic [nbpf_pkg::RootW-1:0] r_res;
    logic [nbpf_pkg::BitW-1:0]  r_bit;

    logic [nbpf_pkg::LimW-1:0]  r_mag;
    logic [nbpf_pkg::ProdW-1:0] r_cr [3];
    logic [nbpf_pkg::ProdW-1:0] r_cden;
    logic [nbpf_pkg::QW-1:0]    r_cq [3];
    logic                       r_neg [3];

    logic signed [nbpf_pkg::ForceW-1:0] r_sum [3];
    logic                               r_seen;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] in_addr;
    logic          idx_ok;
    logic signed [2*nbpf_pkg::DiffW-1:0] sq_full [3];
    logic [nbpf_pkg::NumW-1:0]  num_full;
    logic [nbpf_pkg::GmW-1:0]   gm_full;
    logic [nbpf_pkg::RootW-1:0] root_try;
    logic [nbpf_pkg::DdenW-1:0] div_diff;
    logic                       div_ge;
    logic [nbpf_pkg::DiffW-1:0] abs_d [3];
    logic [nbpf_pkg::ProdW-1:0] prod [3];
    logic                       cdiv_ge [3];

    assign in_addr = AW'(i_body_index);
    assign idx_ok  = (32'(i_body_index) < MAX_BODIES);
    assign rd_addr = i_cmd.rd_input ? in_addr : r_j[AW-1:0];

    // Table memories: one write port for loads, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we && idx_ok) begin
            mem_x[in_addr] <= i_pos_x;
            mem_y[in_addr] <= i_pos_y;
            mem_z[in_addr] <= i_pos_z;
            mem_m[in_addr] <= i_body_mass;
        end
        r_rd_p[0] <= mem_x[rd_addr];
        r_rd_p[1] <= mem_y[rd_addr];
        r_rd_p[2] <= mem_z[rd_addr];
        r_rd_m    <= mem_m[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= nbpf_pkg::BodyCountReset;
            r_cfg_g     <= nbpf_pkg::GravityReset;
            r_cfg_lim   <= nbpf_pkg::LimitReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                nbpf_pkg::CFG_BODY_COUNT:  r_cfg_count <= i_cfg_data[nbpf_pkg::CountW-1:0];
                nbpf_pkg::CFG_GRAVITY:     r_cfg_g     <= i_cfg_data[nbpf_pkg::GravW-1:0];
                nbpf_pkg::CFG_FORCE_LIMIT: r_cfg_lim   <= i_cfg_data[nbpf_pkg::LimW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sq_full[k] = r_d[k] * r_d[k];
            abs_d[k]   = r_d[k][nbpf_pkg::DiffW-1] ? nbpf_pkg::DiffW'(-r_d[k])
                                                   : nbpf_pkg::DiffW'(r_d[k]);
            prod[k]    = nbpf_pkg::ProdW'(abs_d[k]) * nbpf_pkg::ProdW'(r_mag);
            cdiv_ge[k] = (r_cr[k] >= r_cden);
        end
    end

    assign gm_full  = nbpf_pkg::GmW'(r_cfg_g) * nbpf_pkg::GmW'(r_rd_m);
    assign num_full = nbpf_pkg::NumW'(r_gm) * nbpf_pkg::NumW'(r_mj);
    assign root_try = r_res + nbpf_pkg::RootW'(r_bit);
    assign div_ge   = (nbpf_pkg::DdenW'(r_dr) >= r_dden);
    assign div_diff = nbpf_pkg::DdenW'(r_dr) - r_dden;

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_start) begin
            r_home  <= in_addr;
            r_count <= (32'(r_cfg_count) > MAX_BODIES) ? CW'(MAX_BODIES) : CW'(r_cfg_count);
            r_j     <= '0;
        end else if (i_cmd.j_inc) begin
            r_j <= r_j + 1'b1;
        end

        if (i_cmd.home_load) begin
            for (int k = 0; k < 3; k++) r_home_p[k] <= r_rd_p[k];
            r_gm <= gm_full;
        end

        if (i_cmd.diff_load) begin
            for (int k = 0; k < 3; k++) begin
                r_d[k] <= $signed({r_rd_p[k][nbpf_pkg::PosW-1], r_rd_p[k]})
                        - $signed({r_home_p[k][nbpf_pkg::PosW-1], r_home_p[k]});
            end
            r_mj <= r_rd_m;
        end

        if (i_cmd.sq_load) begin
            for (int k = 0; k < 3; k++) r_sq[k] <= sq_full[k][nbpf_pkg::SqW-1:0];
            r_num <= num_full;
        end

        if (i_cmd.sum_load) begin
            r_d2 <= nbpf_pkg::D2W'(r_sq[0]) + nbpf_pkg::D2W'(r_sq[1])
                  + nbpf_pkg::D2W'(r_sq[2]);
        end

        // The quotient overflows Q8.16 exactly when num >= 256 * d2.
        if (i_cmd.iter_init) begin
            r_sat  <= ((nbpf_pkg::D2W + 8)'(r_num) >= {r_d2, 8'h00});
            r_dr   <= {r_num, 16'h0000};
            r_dden <= {r_d2, (nbpf_pkg::QW - 1)'(0)};
            r_q    <= '0;
            r_rx   <= nbpf_pkg::RootW'(r_d2);
            r_res  <= '0;
            r_bit  <= nbpf_pkg::BitW'(1) << (nbpf_pkg::BitW - 1);
        end else begin
            if (i_cmd.root_step) begin
                if (r_rx >= root_try) begin
                    r_rx  <= r_rx - root_try;
                    r_res <= (r_res >> 1) + nbpf_pkg::RootW'(r_bit);
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            if (i_cmd.div_step) begin
                if (div_ge) r_dr <= div_diff[nbpf_pkg::DrW-1:0];
                r_q    <= {r_q[nbpf_pkg::QW-2:0], div_ge};
                r_dden <= r_dden >> 1;
            end
        end

        if (i_cmd.mag_load) begin
            r_mag <= (r_sat || r_q >= r_cfg_lim) ? r_cfg_lim : r_q;
        end

        if (i_cmd.mul_load) begin
            for (int k = 0; k < 3; k++) begin
                r_cr[k]  <= prod[k];
                r_neg[k] <= r_d[k][nbpf_pkg::DiffW-1];
                r_cq[k]  <= '0;
            end
            r_cden <= {r_res[nbpf_pkg::DistW-1:0], (nbpf_pkg::QW - 1)'(0)};
        end else if (i_cmd.cdiv_step) begin
            for (int k = 0; k < 3; k++) begin
                if (cdiv_ge[k]) r_cr[k] <= r_cr[k] - r_cden;
                r_cq[k] <= {r_cq[k][nbpf_pkg::QW-2:0], cdiv_ge[k]};
            end
            r_cden <= r_cden >> 1;
        end

        if (i_cmd.query_start) begin
            for (int k = 0; k < 3; k++) r_sum[k] <= '0;
            r_seen <= 1'b0;
        end else begin
            if (i_cmd.acc_add) begin
                for (int k = 0; k < 3; k++) begin
                    r_sum[k] <= r_neg[k] ? r_sum[k] - $signed(nbpf_pkg::ForceW'(r_cq[k]))
                                         : r_sum[k] + $signed(nbpf_pkg::ForceW'(r_cq[k]));
                end
            end
            if (i_cmd.seen_set) r_seen <= 1'b1;
        end

        if (i_cmd.out_load) begin
            o_force_x         <= r_sum[0];
            o_force_y         <= r_sum[1];
            o_force_z         <= r_sum[2];
            o_coincident_seen <= r_seen;
        end
    end

    assign o_stat.idx_ok  = idx_ok;
    assign o_stat.j_end   = (r_j >= r_count);
    assign o_stat.j_home  = (r_j == CW'(r_home));
    assign o_stat.d2_zero = (r_d2 == '0);

endmodule

FILE: rtl/core/nbody_pairwise_force_sum_core.sv
// Net gravitational force on one body of a stored table, summed pair by pair.
// Use: the input channel i_in carries transactions of two kinds. A load
// (kind 0) writes position and mass of one table entry. A query (kind 1)
// names a body; the core walks entries 0..min(body_count, MAX_BODIES)-1 and
// returns one transaction on o_out with the net force and a flag that is set
// when a pair at zero distance was skipped.
// For every other body, one shared square root and one restoring divider
// run side by side, each one bit per cycle; three component dividers
// follow. The queried body itself is passed over, and a coincident body
// is skipped after its distance check. Items are handled one at a time;
// i_in.ready is high only between queries. The result sits in an output
// register; the next transaction is accepted while it waits, but a later
// query holds its result until o_out is taken. Reset (i_rst_n low,
// synchronous) returns the registers to their defaults and drops
// o_out.valid; table contents are kept and undefined until loaded.
// Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data; the
// user must write it only while idle, as the core does not enforce this.
module nbody_pairwise_force_sum_core #(
    parameter int MAX_BODIES = nbpf_pkg::MaxBodies
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    nbpf_in_if.sink                       i_in,
    nbpf_out_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic [nbpf_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [nbpf_pkg::CfgDataW-1:0] i_cfg_data
);

    nbpf_pkg::t_cmd  cmd;
    nbpf_pkg::t_stat stat;

    nbpf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_kind   (i_in.kind),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    nbpf_dpath #(
        .MAX_BODIES (MAX_BODIES)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_body_index      (i_in.body_index),
        .i_pos_x           (i_in.pos_x),
        .i_pos_y           (i_in.pos_y),
        .i_pos_z           (i_in.pos_z),
        .i_body_mass       (i_in.body_mass),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_force_x         (o_out.force_x),
        .o_force_y         (o_out.force_y),
        .o_force_z         (o_out.force_z),
        .o_coincident_seen (o_out.coincident_seen)
    );

    // A query keeps the core busy at least for the next cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.kind == nbpf_pkg::KIND_QUERY) |=> !i_in.ready)
        else $error("input accepted right after a query");

    // A load leaves the core ready again in the next cycle.
    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.kind == nbpf_pkg::KIND_LOAD) |=> i_in.ready)
        else $error("load did not return to idle");

    // A new result is only raised at the end of a query, never while idle.
    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(!i_in.ready))
        else $error("result raised while idle");

endmodule

FILE: bench/nbody_pairwise_force_sum_core_chk.sv
`timescale 1ns / 100ps
// Checker for the pairwise force sum core: mirrors the body table and registers,
// predicts the force of every query and compares each result. Needs nbpf_pkg, nbpf_if.
module nbody_pairwise_force_sum_core_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    nbpf_in_if                            i_in,
    nbpf_out_if                           i_out,
    input  logic                          i_cfg_we,
    input  logic [nbpf_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [nbpf_pkg::CfgDataW-1:0] i_cfg_data,
    output int                            o_errors,
    output int                            o_pending
);

    typedef struct {
        logic signed [nbpf_pkg::ForceW-1:0] fx;
        logic signed [nbpf_pkg::ForceW-1:0] fy;
        logic signed [nbpf_pkg::ForceW-1:0] fz;
        logic                               seen;
    } t_force;

    logic signed [nbpf_pkg::PosW-1:0] tab_x [nbpf_pkg::MaxBodies];
    logic signed [nbpf_pkg::PosW-1:0] tab_y [nbpf_pkg::MaxBodies];
    logic signed [nbpf_pkg::PosW-1:0] tab_z [nbpf_pkg::MaxBodies];
    logic [nbpf_pkg::MassW-1:0]       tab_m [nbpf_pkg::MaxBodies];

    logic [nbpf_pkg::CountW-1:0] body_count;
    logic [nbpf_pkg::GravW-1:0]  gravity;
    logic [nbpf_pkg::LimW-1:0]   force_limit;

    t_force force_queue[$];

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 52;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Magnitude in Q8.16: integer quotient first, then 16 fraction bits.
    function automatic longint unsigned pair_mag(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = num / den;
        r = num % den;
        if (q >= 256) return longint'(force_limit);
        for (int k = 0; k < 16; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 1;
            end
        end
        return (q < force_limit) ? q : longint'(force_limit);
    endfunction

    function automatic longint axis_part(longint delta, longint unsigned mag,
                                         longint unsigned root_d);
        longint unsigned a;
        longint unsigned v;
        a = (delta < 0) ? longint'(-delta) : longint'(delta);
        v = (a * mag) / root_d;
        return (delta < 0) ? -longint'(v) : longint'(v);
    endfunction

    function automatic t_force net_force(int idx);
        t_force f;
        longint sx, sy, sz, dx, dy, dz;
        longint unsigned gm, d2, mag, root_d;
        int cnt;
        sx = 0; sy = 0; sz = 0;
        f.seen = 1'b0;
        gm = longint'(gravity) * longint'(tab_m[idx]);
        cnt = (body_count > nbpf_pkg::MaxBodies) ? nbpf_pkg::MaxBodies : int'(body_count);
        for (int j = 0; j < cnt; j++) begin
            if (j != idx) begin
                dx = longint'(tab_x[j]) - longint'(tab_x[idx]);
                dy = longint'(tab_y[j]) - longint'(tab_y[idx]);
                dz = longint'(tab_z[j]) - longint'(tab_z[idx]);
                d2 = dx * dx + dy * dy + dz * dz;
                if (d2 == 0) begin
                    f.seen = 1'b1;
                end else begin
                    mag    = pair_mag(gm * longint'(tab_m[j]), d2);
                    root_d = int_sqrt(d2);
                    sx += axis_part(dx, mag, root_d);
                    sy += axis_part(dy, mag, root_d);
                    sz += axis_part(dz, mag, root_d);
                end
            end
        end
        f.fx = sx[nbpf_pkg::ForceW-1:0];
        f.fy = sy[nbpf_pkg::ForceW-1:0];
        f.fz = sz[nbpf_pkg::ForceW-1:0];
        return f;
    endfunction

    initial begin
        o_errors = 0;
        for (int k = 0; k < nbpf_pkg::MaxBodies; k++) begin
            tab_x[k] = '0; tab_y[k] = '0; tab_z[k] = '0; tab_m[k] = '0;
        end
    end

    assign o_pending = force_queue.size();

    always @(posedge i_clk) begin
        t_force want;
        if (!i_rst_n) begin
            body_count  <= nbpf_pkg::BodyCountReset;
            gravity     <= nbpf_pkg::GravityReset;
            force_limit <= nbpf_pkg::LimitReset;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    nbpf_pkg::CFG_BODY_COUNT:  body_count  <= i_cfg_data[nbpf_pkg::CountW-1:0];
                    nbpf_pkg::CFG_GRAVITY:     gravity     <= i_cfg_data[nbpf_pkg::GravW-1:0];
                    nbpf_pkg::CFG_FORCE_LIMIT: force_limit <= i_cfg_data[nbpf_pkg::LimW-1:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                if (i_in.kind == nbpf_pkg::KIND_LOAD) begin
                    tab_x[i_in.body_index] = i_in.pos_x;
                    tab_y[i_in.body_index] = i_in.pos_y;
                    tab_z[i_in.body_index] = i_in.pos_z;
                    tab_m[i_in.body_index] = i_in.body_mass;
                end else begin
                    force_queue.insert(force_queue.size(),
                                       net_force(int'(i_in.body_index)));
                end
            end
            if (i_out.valid && i_out.ready) begin
                if (force_queue.size() == 0) begin
                    $display("%0t: unexpected result transaction", $time);
                    o_errors++;
                end else begin
                    want = force_queue.pop_front();
                    if (want.fx !== i_out.force_x || want.fy !== i_out.force_y ||
                        want.fz !== i_out.force_z || want.seen !== i_out.coincident_seen) begin
                        $display("%0t: force mismatch exp %0d %0d %0d %b act %0d %0d %0d %b",
                                 $time, want.fx, want.fy, want.fz, want.seen,
                                 i_out.force_x, i_out.force_y, i_out.force_z,
                                 i_out.coincident_seen);
                        o_errors++;
                    end
                end
            end
        end
    end
endmodule

FILE: bench/nbody_pairwise_force_sum_core_tb.sv
`timescale 1ns / 100ps
// Top of the pairwise force sum regression: clock, reset, stimulus and verdict.
// Depends on nbpf_pkg, nbpf_if, the core and nbody_pairwise_force_sum_core_chk.
module nbody_pairwise_force_sum_core_tb;

    localparam int WatchLimit = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [nbpf_pkg::CfgIdxW-1:0]  cfg_index = '0;
    logic [nbpf_pkg::CfgDataW-1:0] cfg_data = '0;
    int errors, pending;

    nbpf_in_if  in_ch();
    nbpf_out_if out_ch();

    nbody_pairwise_force_sum_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    nbody_pairwise_force_sum_core_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    bit written [nbpf_pkg::MaxBodies];
    int filled = 0;
    int loaded_list[$];

    initial begin
        in_ch.valid = 1'b0; in_ch.kind = nbpf_pkg::KIND_LOAD; in_ch.body_index = '0;
        in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0; in_ch.body_mass = '0;
        out_ch.ready = 1'b0;
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    always @(posedge i_clk) begin
        static int stall_left = 0;
        if (hold_req) begin
            stall_left = 3000;
            hold_req = 1'b0;
        end
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        static int idle_cycles = 0;
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WatchLimit) begin
            $display("nbody_pairwise_force_sum_core regression: fail");
            $finish;
        end
    end

    task automatic offer(logic kind, int idx, logic [nbpf_pkg::PosW-1:0] x,
                         logic [nbpf_pkg::PosW-1:0] y, logic [nbpf_pkg::PosW-1:0] z,
                         logic [nbpf_pkg::MassW-1:0] m);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= kind;
        in_ch.body_index <= idx[nbpf_pkg::IdxW-1:0];
        in_ch.pos_x <= x; in_ch.pos_y <= y; in_ch.pos_z <= z;
        in_ch.body_mass <= m;
        do @(negedge i_clk); while (!in_ch.ready);
        @(posedge i_clk);
    endtask

    task automatic load_body(int idx, logic [nbpf_pkg::PosW-1:0] x,
                             logic [nbpf_pkg::PosW-1:0] y, logic [nbpf_pkg::PosW-1:0] z,
                             logic [nbpf_pkg::MassW-1:0] m);
        offer(nbpf_pkg::KIND_LOAD, idx, x, y, z, m);
        if (!written[idx]) loaded_list.insert(loaded_list.size(), idx);
        written[idx] = 1'b1;
        while (filled < nbpf_pkg::MaxBodies && written[filled]) filled++;
    endtask

    task automatic load_random(int idx);
        load_body(idx, nbpf_pkg::PosW'($urandom), nbpf_pkg::PosW'($urandom),
                  nbpf_pkg::PosW'($urandom), nbpf_pkg::MassW'($urandom));
    endtask

    task automatic query_body(int idx);
        offer(nbpf_pkg::KIND_QUERY, idx, nbpf_pkg::PosW'($urandom), nbpf_pkg::PosW'($urandom),
              nbpf_pkg::PosW'($urandom), nbpf_pkg::MassW'($urandom));
    endtask

    // Registers change only with the core idle and nothing outstanding.
    task automatic write_reg(logic [nbpf_pkg::CfgIdxW-1:0] index, int unsigned value);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value[nbpf_pkg::CfgDataW-1:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int idx;
        int unsigned pick;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extreme positions and masses, a coincident pair, zero mass.
        write_reg(nbpf_pkg::CFG_BODY_COUNT, 8);
        load_body(0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF);
        load_body(1, 24'h800000, 24'h800000, 24'h800000, 16'hFFFF);
        load_body(2, 24'h001000, 24'hFFF000, 24'h000000, 16'h0100);
        load_body(3, 24'h001000, 24'hFFF000, 24'h000000, 16'h0040);
        load_body(4, 24'h000001, 24'h000000, 24'h000000, 16'h0000);
        load_body(5, 24'h000000, 24'h000000, 24'h000000, 16'h0010);
        load_random(6);
        load_random(7);
        load_random(2047);
        load_random(1024);
        query_body(0); query_body(1); query_body(2); query_body(4);
        query_body(2047);
        write_reg(nbpf_pkg::CFG_BODY_COUNT, 0);
        query_body(3);
        write_reg(nbpf_pkg::CFG_BODY_COUNT, 1);
        query_body(0);
        write_reg(nbpf_pkg::CFG_BODY_COUNT, 8);
        write_reg(nbpf_pkg::CFG_GRAVITY, 20'hFFFFF);
        write_reg(nbpf_pkg::CFG_FORCE_LIMIT, 24'hFFFFFF);
        query_body(0); query_body(5);
        write_reg(nbpf_pkg::CFG_FORCE_LIMIT, 0);
        query_body(5);
        write_reg(nbpf_pkg::CFG_GRAVITY, 0);
        query_body(6);

        // Random phases over small tables; the last one runs without idling.
        for (int phase = 0; phase < 6; phase++) begin
            quiet = (phase == 5);
            write_reg(nbpf_pkg::CFG_BODY_COUNT, $urandom_range(1, (filled < 16) ? filled : 16));
            pick = $urandom_range(0, 3);
            write_reg(nbpf_pkg::CFG_GRAVITY, (pick == 0) ? nbpf_pkg::GravityReset :
                      $urandom_range(0, 20'hFFFFF));
            pick = $urandom_range(0, 3);
            write_reg(nbpf_pkg::CFG_FORCE_LIMIT, (pick == 0) ? 24'hFFFFFF :
                      (pick == 1) ? nbpf_pkg::LimitReset : $urandom_range(0, 24'hFFFFFF));
            for (int n = 0; n < 45; n++) begin
                if (phase == 2 && n == 10) hold_req = 1'b1;
                if ($urandom_range(0, 1) == 0) begin
                    idx = ($urandom_range(0, 2) == 0) ?
                          loaded_list[$urandom_range(0, loaded_list.size() - 1)] :
                          $urandom_range(0, filled - 1);
                    query_body(idx);
                end else begin
                    idx = ($urandom_range(0, 9) == 0) ?
                          $urandom_range(0, nbpf_pkg::MaxBodies - 1) :
                          $urandom_range(0, filled + 3);
                    if ($urandom_range(0, 4) == 0) begin
                        pick = $urandom_range(0, filled - 1);
                        load_body(idx, chk.tab_x[pick], chk.tab_y[pick], chk.tab_z[pick],
                                  nbpf_pkg::MassW'($urandom));
                    end else begin
                        load_random(idx);
                    end
                end
            end
        end
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("nbody_pairwise_force_sum_core regression: pass");
        else
            $display("nbody_pairwise_force_sum_core regression: fail");
        $finish;
    end
endmodule

FILE: nbody_pairwise_force_sum_core.f
rtl/core/nbpf_pkg.sv
rtl/core/nbpf_if.sv
rtl/core/nbpf_ctrl.sv
rtl/core/nbpf_dpath.sv
rtl/core/nbody_pairwise_force_sum_core.sv
bench/nbody_pairwise_force_sum_core_chk.sv
bench/nbody_pairwise_force_sum_core_tb.sv
